>>> design/posting_list_builder_core_defines.svh
// Assertion helpers used by the checker file.
// Both expect signals named clk and arst_n in the using scope.
`ifndef POSTING_LIST_BUILDER_CORE_DEFINES_SVH
`define POSTING_LIST_BUILDER_CORE_DEFINES_SVH

`define PLB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define PLB_ASSERT_NEXT(label, ante, cons, msg) \
	`PLB_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> design/plb_pkg.sv
`default_nettype none
package plb_pkg;

	localparam int MAX_POSITIONS = 32;
	localparam int ID_W = 31;
	localparam int OFS_W = 40;
	localparam int WORD_BYTES = 4;
	localparam int HDR_WORDS = 2;
	localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
	localparam int ADDR_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int BYTE_SHIFT = $clog2(WORD_BYTES);

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_POS = 2'd1;
	localparam logic [1:0] KIND_DIR = 2'd2;

	localparam logic ACT_POSTING = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	typedef struct packed {
		logic action;
		logic [ID_W-1:0] word;
		logic [ID_W-1:0] document;
		logic [ID_W-1:0] offset_in_doc;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [ID_W-1:0] out_word;
		logic [ID_W-1:0] out_document;
		logic [ID_W-1:0] out_position;
		logic [ID_W-1:0] out_count;
		logic [OFS_W-1:0] list_start;
		logic dropped;
		logic final_res;
	} res_t;

	typedef struct packed {
		logic load;
		logic open_new;
		logic store_pos;
		logic emit_hdr;
		logic rd_pos;
		logic emit_pos;
		logic emit_dir;
		logic finish_close;
		logic group_switch;
	} cmd_t;

	typedef struct packed {
		logic pend_finish;
		logic group_open;
		logic same_group;
		logic more_pos;
		logic need_dir;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> design/plb_posting_if.sv
`default_nettype none
interface plb_posting_if
	import plb_pkg::*;
();
	logic valid;
	logic ready;
	logic action;
	logic [ID_W-1:0] word;
	logic [ID_W-1:0] document;
	logic [ID_W-1:0] offset_in_doc;

	modport source (output valid, action, word, document, offset_in_doc, input ready);
	modport sink (input valid, action, word, document, offset_in_doc, output ready);
endinterface
`default_nettype wire

>>> design/plb_result_if.sv
`default_nettype none
interface plb_result_if
	import plb_pkg::*;
();
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [ID_W-1:0] out_word;
	logic [ID_W-1:0] out_document;
	logic [ID_W-1:0] out_position;
	logic [ID_W-1:0] out_count;
	logic [OFS_W-1:0] list_start;
	logic dropped;
	logic final_res;

	modport source (output valid, kind, out_word, out_document, out_position, out_count,
		list_start, dropped, final_res, input ready);
	modport sink (input valid, kind, out_word, out_document, out_position, out_count,
		list_start, dropped, final_res, output ready);
endinterface
`default_nettype wire

>>> design/plb_datapath.sv
`default_nettype none
module plb_datapath
	import plb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire item_t item,
	input  wire cmd_t cmd,
	input  wire logic res_ready,
	output sts_t sts,
	output logic res_valid,
	output res_t res
);

	localparam logic [ID_W-1:0] DOCS_MAX = {ID_W{1'b1}};

	item_t pend_q;
	logic group_open_q;
	logic [ID_W-1:0] cur_word_q;
	logic [ID_W-1:0] cur_doc_q;
	logic [CNT_W-1:0] cnt_q;
	logic ovf_q;
	logic [OFS_W-1:0] boff_q;
	logic [OFS_W-1:0] wstart_q;
	logic [ID_W-1:0] docs_q;
	logic [CNT_W-1:0] idx_q;
	logic [ID_W-1:0] rd_data_q;
	logic res_valid_q;
	res_t res_q;

	logic [ID_W-1:0] mem_q [MAX_POSITIONS];
	logic mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [OFS_W-1:0] rec_bytes;
	logic cnt_full;

	assign cnt_full = (cnt_q >= CNT_W'(MAX_POSITIONS));
	assign rec_bytes = (OFS_W'(cnt_q) + OFS_W'(HDR_WORDS)) << BYTE_SHIFT;

	always_comb begin
		sts.pend_finish = (pend_q.action == ACT_FINISH);
		sts.group_open = group_open_q;
		sts.same_group = (pend_q.word == cur_word_q) && (pend_q.document == cur_doc_q);
		sts.more_pos = (idx_q < cnt_q);
		sts.need_dir = (pend_q.action == ACT_FINISH) || (pend_q.word != cur_word_q);
		sts.out_free = !res_valid_q || res_ready;
	end

	always_comb begin
		mem_we = cmd.open_new || cmd.group_switch || (cmd.store_pos && !cnt_full);
		mem_wa = (cmd.store_pos) ? cnt_q[ADDR_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= pend_q.offset_in_doc;
		end
		if (cmd.rd_pos) begin
			rd_data_q <= mem_q[idx_q[ADDR_W-1:0]];
		end
		if (cmd.load) begin
			pend_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_open_q <= 1'b0;
			cur_word_q <= '0;
			cur_doc_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			boff_q <= '0;
			wstart_q <= '0;
			docs_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.open_new) begin
				group_open_q <= 1'b1;
				cur_word_q <= pend_q.word;
				cur_doc_q <= pend_q.document;
				cnt_q <= CNT_W'(1);
				ovf_q <= 1'b0;
				wstart_q <= boff_q;
				docs_q <= ID_W'(1);
			end
			if (cmd.store_pos) begin
				if (cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.emit_hdr) begin
				idx_q <= '0;
				boff_q <= boff_q + rec_bytes;
			end
			if (cmd.rd_pos) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.finish_close) begin
				group_open_q <= 1'b0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				docs_q <= '0;
				wstart_q <= boff_q;
			end
			if (cmd.group_switch) begin
				cur_word_q <= pend_q.word;
				cur_doc_q <= pend_q.document;
				cnt_q <= CNT_W'(1);
				ovf_q <= 1'b0;
				if (sts.need_dir) begin
					wstart_q <= boff_q;
					docs_q <= ID_W'(1);
				end else if (docs_q != DOCS_MAX) begin
					docs_q <= docs_q + ID_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_hdr || cmd.emit_pos || cmd.emit_dir) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_hdr) begin
			res_q <= '{kind: KIND_HDR, out_word: cur_word_q, out_document: cur_doc_q,
				out_position: '0, out_count: ID_W'(cnt_q), list_start: '0,
				dropped: ovf_q, final_res: 1'b0};
		end else if (cmd.emit_pos) begin
			res_q <= '{kind: KIND_POS, out_word: cur_word_q, out_document: cur_doc_q,
				out_position: rd_data_q, out_count: '0, list_start: '0,
				dropped: 1'b0, final_res: !sts.more_pos && !sts.need_dir};
		end else if (cmd.emit_dir) begin
			res_q <= '{kind: KIND_DIR, out_word: cur_word_q, out_document: '0,
				out_position: '0, out_count: docs_q, list_start: wstart_q,
				dropped: 1'b0, final_res: 1'b1};
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
`default_nettype wire

>>> design/plb_controller.sv
`default_nettype none
module plb_controller
	import plb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DECIDE  = 7'b0000010,
		ST_HDR     = 7'b0000100,
		ST_POS_RD  = 7'b0001000,
		ST_POS_OUT = 7'b0010000,
		ST_DIR     = 7'b0100000,
		ST_UPD     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.pend_finish) begin
					state_nxt = sts.group_open ? ST_HDR : ST_IDLE;
				end else if (!sts.group_open) begin
					cmd.open_new = 1'b1;
					state_nxt = ST_IDLE;
				end else if (sts.same_group) begin
					cmd.store_pos = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_HDR;
				end
			end
			ST_HDR: begin
				if (sts.out_free) begin
					cmd.emit_hdr = 1'b1;
					state_nxt = ST_POS_RD;
				end
			end
			ST_POS_RD: begin
				cmd.rd_pos = 1'b1;
				state_nxt = ST_POS_OUT;
			end
			ST_POS_OUT: begin
				if (sts.out_free) begin
					cmd.emit_pos = 1'b1;
					if (sts.more_pos) begin
						state_nxt = ST_POS_RD;
					end else if (sts.need_dir) begin
						state_nxt = ST_DIR;
					end else begin
						state_nxt = ST_UPD;
					end
				end
			end
			ST_DIR: begin
				if (sts.out_free) begin
					cmd.emit_dir = 1'b1;
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				if (sts.pend_finish) begin
					cmd.finish_close = 1'b1;
				end else begin
					cmd.group_switch = 1'b1;
				end
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/posting_list_builder_core.sv
// Posting list builder.
// posting channel: postings (action 0) sorted by word then document, or a
// finish (action 1) that flushes the open group. result channel: document
// headers, position entries and word directory entries; final_res marks the
// last result of the transfer that caused them.
// One posting is taken at a time: ready is high only while the sequencer is
// idle. A posting that joins or opens a group is loaded, then decided and
// stored. A closing item is decided, then emits the header, then for each
// stored position a memory read and an output register load, then a
// directory entry when the word changes or on a finish, then updates the
// group. The position memory has one read port, so each position takes a
// read step and then an output step.
// result is driven from an output register; a stall there holds the sequencer
// in its current emit state and no result is lost.
// Reset clears the group, counters and byte offset; the position memory is
// not cleared (only entries written in the open group are read).
`default_nettype none
module posting_list_builder_core
	import plb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	plb_posting_if.sink posting,
	plb_result_if.source result
);

	item_t item;
	cmd_t cmd;
	sts_t sts;
	res_t res;
	logic res_valid;
	logic in_ready;

	assign item = '{action: posting.action, word: posting.word,
		document: posting.document, offset_in_doc: posting.offset_in_doc};

	plb_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (posting.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	plb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.res_ready (result.ready),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

	assign posting.ready = in_ready;
	assign result.valid = res_valid;
	assign result.kind = res.kind;
	assign result.out_word = res.out_word;
	assign result.out_document = res.out_document;
	assign result.out_position = res.out_position;
	assign result.out_count = res.out_count;
	assign result.list_start = res.list_start;
	assign result.dropped = res.dropped;
	assign result.final_res = res.final_res;

endmodule
`default_nettype wire

>>> design/plb_checker.sv
`default_nettype none
`include "posting_list_builder_core_defines.svh"
module plb_checker
	import plb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] kind,
	input wire logic [ID_W-1:0] out_document,
	input wire logic [ID_W-1:0] out_count,
	input wire logic [OFS_W-1:0] list_start,
	input wire logic dropped,
	input wire logic final_res
);

	`PLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`PLB_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready after posting transfer")
	`PLB_ASSERT(a_dir_fields, !(out_valid && kind == KIND_DIR) || (out_document == '0 && !dropped && final_res), "bad directory entry")
	`PLB_ASSERT(a_hdr_fields, !(out_valid && kind == KIND_HDR) || (list_start == '0 && !final_res && out_count != '0), "bad document header")

endmodule

bind posting_list_builder_core plb_checker u_plb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (posting.valid),
	.in_ready     (posting.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.kind         (result.kind),
	.out_document (result.out_document),
	.out_count    (result.out_count),
	.list_start   (result.list_start),
	.dropped      (result.dropped),
	.final_res    (result.final_res)
);
`default_nettype wire
